// File: rtl/upf_pkg.sv
// ----------------------------------------------------------------------------
// upf_pkg
// Shared types and constants of the scanline unfilter: field widths, filter
// codes, register indexes and the result beat layout.
// ----------------------------------------------------------------------------
package upf_pkg;

   localparam int DEF_MAX_ROW_BYTES = 8192;
   localparam int DEF_MAX_CHANNELS  = 4;

   localparam int BYTE_W      = 8;
   localparam int FTYPE_W     = 3;
   localparam int ROW_BYTES_W = 14;
   localparam int BPP_W       = 3;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 14;

   localparam int CMD_QUEUE_DEPTH = 2;
   localparam int RSP_QUEUE_DEPTH = 2;

   localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RESET = ROW_BYTES_W'(1);
   localparam logic [BPP_W-1:0]       BPP_RESET       = BPP_W'(1);

   typedef enum logic [FTYPE_W-1:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filter_type_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROW_BYTES       = 1'b0,
      CSR_BYTES_PER_PIXEL = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                  wen;
      csr_index_type         idx;
      logic [CSR_DATA_W-1:0] data;
   } csr_beat_type;

   typedef struct packed {
      logic [BYTE_W-1:0] pixel_byte;
      logic              row_end;
   } rsp_beat_type;

endpackage

// File: rtl/upf_queue.sv
// ----------------------------------------------------------------------------
// upf_queue
// Small register FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module upf_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   import upf_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/upf_front.sv
// ----------------------------------------------------------------------------
// upf_front
// Front end: holds the registers, tracks column, channel and first row, and
// classifies every accepted byte into a command beat for the back end.
// ----------------------------------------------------------------------------
module upf_front #(
   parameter int   MAX_ROW_BYTES = upf_pkg::DEF_MAX_ROW_BYTES,
   parameter int   MAX_CHANNELS  = upf_pkg::DEF_MAX_CHANNELS,
   localparam int  AW  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1,
   localparam int  CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
   localparam int  CMD_W = upf_pkg::BYTE_W + upf_pkg::FTYPE_W + 3 + CHW + AW
) (
   input  logic                                clock,
   input  logic                                reset,
   input  upf_pkg::csr_beat_type               csr,
   input  logic                                accept,
   input  logic [upf_pkg::BYTE_W-1:0]          filtered_byte,
   input  logic [upf_pkg::FTYPE_W-1:0]         filter_type,
   input  logic                                frame_start,
   output logic [CMD_W-1:0]                    cmd_data
);
   import upf_pkg::*;

   localparam int LW   = $clog2(MAX_ROW_BYTES + 1);
   localparam int XW   = (LW > ROW_BYTES_W) ? LW : ROW_BYTES_W;
   localparam int BQ   = $clog2(MAX_CHANNELS + 1);
   localparam int BW   = (BQ > BPP_W) ? BQ : BPP_W;

   typedef struct packed {
      logic [BYTE_W-1:0]  fbyte;
      logic [FTYPE_W-1:0] ftype;
      logic               first_row;
      logic               first_pixel;
      logic               last;
      logic [CHW-1:0]     ch;
      logic [AW-1:0]      col;
   } cmd_type;

   logic [ROW_BYTES_W-1:0] row_bytes_ff, row_bytes_in;
   logic [BPP_W-1:0]       bpp_ff, bpp_in;
   logic [AW-1:0]          column_ff, column_in;
   logic                   first_row_ff, first_row_in;
   logic [CHW-1:0]         mod_ff [MAX_CHANNELS];
   logic [CHW-1:0]         mod_in [MAX_CHANNELS];
   logic [CHW-1:0]         mod_cur [MAX_CHANNELS];

   logic [XW-1:0]  row_x, len_eff;
   logic [BW-1:0]  bpp_x, bpp_eff, bpp_m1;
   logic [AW-1:0]  col_cur;
   logic [XW-1:0]  col_x, col_next_x;
   logic           first_row_cur;
   logic           first_pixel;
   logic           last;
   logic [CHW-1:0] ch;
   cmd_type        cmd;

   // register writes
   always_comb begin
      row_bytes_in = row_bytes_ff;
      bpp_in       = bpp_ff;
      if (csr.wen) begin
         unique case (csr.idx)
            CSR_ROW_BYTES:       row_bytes_in = csr.data[ROW_BYTES_W-1:0];
            CSR_BYTES_PER_PIXEL: bpp_in       = csr.data[BPP_W-1:0];
            default:             row_bytes_in = row_bytes_ff;
         endcase
      end
   end

   // effective row length and channel count, zero as one, saturated at the top
   always_comb begin
      row_x   = XW'(row_bytes_ff);
      len_eff = (row_x == '0) ? XW'(1) :
                (row_x > XW'(MAX_ROW_BYTES)) ? XW'(MAX_ROW_BYTES) : row_x;
      bpp_x   = BW'(bpp_ff);
      bpp_eff = (bpp_x == '0) ? BW'(1) :
                (bpp_x > BW'(MAX_CHANNELS)) ? BW'(MAX_CHANNELS) : bpp_x;
      bpp_m1  = bpp_eff - BW'(1);
   end

   // position of this byte
   always_comb begin
      col_cur       = frame_start ? '0 : column_ff;
      first_row_cur = frame_start | first_row_ff;
      for (int k = 0; k < MAX_CHANNELS; k++) begin
         mod_cur[k] = frame_start ? '0 : mod_ff[k];
      end
      ch          = mod_cur[bpp_m1[CHW-1:0]];
      col_x       = XW'(col_cur);
      col_next_x  = col_x + XW'(1);
      first_pixel = (col_x < XW'(bpp_eff));
      last        = (col_next_x >= len_eff);
   end

   // column and per-count channel counters (mod_ff[k] runs modulo k+1)
   always_comb begin
      column_in    = column_ff;
      first_row_in = first_row_ff;
      for (int k = 0; k < MAX_CHANNELS; k++) begin
         mod_in[k] = mod_ff[k];
      end
      if (accept) begin
         if (last) begin
            column_in    = '0;
            first_row_in = 1'b0;
            for (int k = 0; k < MAX_CHANNELS; k++) begin
               mod_in[k] = '0;
            end
         end else begin
            column_in    = col_cur + AW'(1);
            first_row_in = first_row_cur;
            for (int k = 0; k < MAX_CHANNELS; k++) begin
               mod_in[k] = (mod_cur[k] == CHW'(k)) ? '0 : mod_cur[k] + CHW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_bytes_ff <= ROW_BYTES_RESET;
         bpp_ff       <= BPP_RESET;
         column_ff    <= '0;
         first_row_ff <= 1'b1;
         for (int k = 0; k < MAX_CHANNELS; k++) begin
            mod_ff[k] <= '0;
         end
      end else begin
         row_bytes_ff <= row_bytes_in;
         bpp_ff       <= bpp_in;
         column_ff    <= column_in;
         first_row_ff <= first_row_in;
         for (int k = 0; k < MAX_CHANNELS; k++) begin
            mod_ff[k] <= mod_in[k];
         end
      end
   end

   always_comb begin
      cmd.fbyte       = filtered_byte;
      cmd.ftype       = filter_type;
      cmd.first_row   = first_row_cur;
      cmd.first_pixel = first_pixel;
      cmd.last        = last;
      cmd.ch          = ch;
      cmd.col         = col_cur;
      cmd_data        = cmd;
   end

endmodule

// File: rtl/upf_back.sv
// ----------------------------------------------------------------------------
// upf_back
// Back end: line buffer read, predictor and modulo add. One execute stage
// holds the command while its above byte comes out of the line buffer.
// ----------------------------------------------------------------------------
module upf_back #(
   parameter int   MAX_ROW_BYTES = upf_pkg::DEF_MAX_ROW_BYTES,
   parameter int   MAX_CHANNELS  = upf_pkg::DEF_MAX_CHANNELS,
   localparam int  AW  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1,
   localparam int  CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
   localparam int  CMD_W = upf_pkg::BYTE_W + upf_pkg::FTYPE_W + 3 + CHW + AW
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_empty,
   input  logic [CMD_W-1:0]       cmd_data,
   output logic                   cmd_pop,
   input  logic                   rsp_full,
   output logic                   rsp_push,
   output upf_pkg::rsp_beat_type  rsp_beat
);
   import upf_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0]  fbyte;
      logic [FTYPE_W-1:0] ftype;
      logic               first_row;
      logic               first_pixel;
      logic               last;
      logic [CHW-1:0]     ch;
      logic [AW-1:0]      col;
   } cmd_type;

   logic [BYTE_W-1:0] line_mem [MAX_ROW_BYTES];
   logic [BYTE_W-1:0] above_ff;
   logic              ex_valid_ff, ex_valid_in;
   cmd_type           ex_cmd_ff;
   cmd_type           cmd_head;
   logic [BYTE_W-1:0] left_ff  [MAX_CHANNELS];
   logic [BYTE_W-1:0] uleft_ff [MAX_CHANNELS];

   logic              ex_done, load;
   logic [BYTE_W-1:0] a, b, c, pred, res;
   logic [BYTE_W:0]   avg_sum;
   logic signed [9:0] p_a, p_b, p_c;
   logic [9:0]        d_a, d_b, d_c;

   assign cmd_head = cmd_data;
   assign ex_done  = ex_valid_ff & ~rsp_full;
   assign load     = ~cmd_empty & (~ex_valid_ff | ex_done);
   assign cmd_pop  = load;

   always_comb begin
      ex_valid_in = ex_valid_ff;
      if (load) begin
         ex_valid_in = 1'b1;
      end else if (ex_done) begin
         ex_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff <= 1'b0;
      end else begin
         ex_valid_ff <= ex_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ex_cmd_ff <= cmd_head;
      end
   end

   // line buffer; a byte retiring this cycle at the same column is forwarded
   always_ff @(posedge clock) begin
      if (ex_done) begin
         line_mem[ex_cmd_ff.col] <= res;
      end
      if (load) begin
         if (ex_done && (ex_cmd_ff.col == cmd_head.col)) begin
            above_ff <= res;
         end else begin
            above_ff <= line_mem[cmd_head.col];
         end
      end
   end

   // neighbours
   always_comb begin
      a = ex_cmd_ff.first_pixel ? '0 : left_ff[ex_cmd_ff.ch];
      b = ex_cmd_ff.first_row ? '0 : above_ff;
      c = (ex_cmd_ff.first_pixel | ex_cmd_ff.first_row) ? '0 : uleft_ff[ex_cmd_ff.ch];
   end

   // Paeth: ties go left, then above, then upper-left
   always_comb begin
      p_a = $signed({2'b00, b}) - $signed({2'b00, c});
      p_b = $signed({2'b00, a}) - $signed({2'b00, c});
      p_c = p_a + p_b;
      d_a = p_a[9] ? 10'(-p_a) : 10'(p_a);
      d_b = p_b[9] ? 10'(-p_b) : 10'(p_b);
      d_c = p_c[9] ? 10'(-p_c) : 10'(p_c);
      avg_sum = {1'b0, a} + {1'b0, b};
   end

   always_comb begin
      unique case (ex_cmd_ff.ftype)
         FILT_SUB:   pred = a;
         FILT_UP:    pred = b;
         FILT_AVG:   pred = avg_sum[BYTE_W:1];
         FILT_PAETH: begin
            if ((d_a <= d_b) && (d_a <= d_c)) begin
               pred = a;
            end else if (d_b <= d_c) begin
               pred = b;
            end else begin
               pred = c;
            end
         end
         default:    pred = '0;
      endcase
      res = ex_cmd_ff.fbyte + pred;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_CHANNELS; k++) begin
            left_ff[k]  <= '0;
            uleft_ff[k] <= '0;
         end
      end else if (ex_done) begin
         left_ff[ex_cmd_ff.ch]  <= res;
         uleft_ff[ex_cmd_ff.ch] <= b;
      end
   end

   assign rsp_push            = ex_done;
   assign rsp_beat.pixel_byte = res;
   assign rsp_beat.row_end    = ex_cmd_ff.last;

endmodule

// File: rtl/png_scanline_unfilter_core.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter_core
// Reverses PNG scanline filtering (None, Sub, Up, Average, Paeth) for 8-bit
// samples, one byte per clock when not stalled, with a line buffer of the previous row.
//
//   channel  direction  handshake        payload
//   req      in         push / full      filtered_byte, filter_type, frame_start
//   rsp      out        empty / pop      pixel_byte, row_end
//   csr      in         write_enable     index, write_data (no wait, no read)
//
// Rate: one beat in and one beat out per clock, sustained while neither side
//   stalls. A beat passes the command queue, then the execute stage with the
//   line buffer read, and waits in the result queue for the rsp ports.
// The loop that sets the rate is the execute stage: predictor and modulo add,
//   with the left byte fed back from its own register.
// Stalls: req and rsp stall on their own; the command queue keeps taking
//   beats while results wait, until it fills.
// Reset: synchronous; clears queues, counters and neighbour bytes. The line
//   buffer needs no clearing, as the first row after frame start reads zero.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_core #(
   parameter int MAX_ROW_BYTES = upf_pkg::DEF_MAX_ROW_BYTES,
   parameter int MAX_CHANNELS  = upf_pkg::DEF_MAX_CHANNELS
) (
   input  logic                               clock,
   input  logic                               reset,
   // input side
   input  logic                               push,
   output logic                               full,
   input  logic [upf_pkg::BYTE_W-1:0]         req_filtered_byte,
   input  logic [upf_pkg::FTYPE_W-1:0]        req_filter_type,
   input  logic                               req_frame_start,
   // result side
   output logic                               empty,
   input  logic                               pop,
   output logic [upf_pkg::BYTE_W-1:0]         rsp_pixel_byte,
   output logic                               rsp_row_end,
   // register writes
   input  logic                               csr_write_enable,
   input  logic [upf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [upf_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import upf_pkg::*;

   localparam int AW    = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
   localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CMD_W = BYTE_W + FTYPE_W + 3 + CHW + AW;
   localparam int RSP_W = $bits(rsp_beat_type);

   csr_beat_type     csr;
   logic             req_accept;
   logic [CMD_W-1:0] cmd_wdata, cmd_rdata;
   logic             cmd_full, cmd_empty, cmd_pop;
   logic             rsp_push, rsp_full;
   rsp_beat_type     rsp_wbeat, rsp_rbeat;
   logic [RSP_W-1:0] rsp_rdata;

   assign csr.wen  = csr_write_enable;
   assign csr.idx  = csr_index_type'(csr_index);
   assign csr.data = csr_write_data;

   // a beat is taken whenever the command queue has room
   assign full       = cmd_full;
   assign req_accept = push & ~cmd_full;

   upf_front #(
      .MAX_ROW_BYTES (MAX_ROW_BYTES),
      .MAX_CHANNELS  (MAX_CHANNELS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr           (csr),
      .accept        (req_accept),
      .filtered_byte (req_filtered_byte),
      .filter_type   (req_filter_type),
      .frame_start   (req_frame_start),
      .cmd_data      (cmd_wdata)
   );

   // decouples classification from execution
   upf_queue #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (cmd_wdata),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_rdata),
      .empty     (cmd_empty)
   );

   upf_back #(
      .MAX_ROW_BYTES (MAX_ROW_BYTES),
      .MAX_CHANNELS  (MAX_CHANNELS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_rdata),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_beat  (rsp_wbeat)
   );

   // result queue: the output register and skid space for a stalled pop
   upf_queue #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_wbeat),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_rdata),
      .empty     (empty)
   );

   assign rsp_rbeat      = rsp_rdata;
   assign rsp_pixel_byte = rsp_rbeat.pixel_byte;
   assign rsp_row_end    = rsp_rbeat.row_end;

endmodule
